// ===== hw/rtl/aabb_frustum_cull_assert.svh =====
// Assertion macros shared by the frustum cull checker.
// Plain text macros only; no dependencies.
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AAFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aafc assertion failed");

// next-cycle implication, disabled in reset
`define AAFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aafc assertion failed");

`endif

// ===== hw/rtl/aafc_pkg.sv =====
// Shared widths, types and register codes of the box frustum cull block.
// No dependencies.
package aafc_pkg;

  localparam int COORD_W   = 32;
  localparam int REG_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = REG_SEL_W + 1;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_AXES  = 3;
  localparam int NUM_CORN  = 8;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int PSUM_W    = PROD_W + 1;
  localparam int CLIP_W    = PROD_W + 2;
  localparam int CMP_W     = PROD_W + 3;
  localparam int NUM_STG   = 6;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS23 = 3'd7;

  // identity matrix, Q16.16
  localparam logic [REG_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] ZERO_REG = '0;

endpackage

// ===== hw/rtl/aafc_box_if.sv =====
// Input channel of the frustum cull block: one box per item.
// Depends on aafc_pkg.
interface aafc_box_if import aafc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t lo_x;
  coord_t lo_y;
  coord_t lo_z;
  coord_t hi_x;
  coord_t hi_y;
  coord_t hi_z;

  modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
  modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

// ===== hw/rtl/aafc_res_if.sv =====
// Result channel of the frustum cull block: one visibility flag per item.
// Depends on aafc_pkg.
interface aafc_res_if import aafc_pkg::*; ();
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

// ===== hw/rtl/aabb_frustum_cull.sv =====
// Box frustum cull: each item is a box (min and max corners, signed Q16.16).
// All eight corners are transformed by the configured 4x4 matrix with exact
// arithmetic, and the box is reported culled when every corner lies beyond
// the same clip plane. One box is accepted per cycle unless back-pressure stalls
// the pipeline; the result passes through a six-stage pipeline (input register,
// 24 parallel 32x32 multipliers, partial sums, corner sums, plane compares,
// reduction). Each stage holds its item under back-pressure independently.
// Matrix writes take effect at once and must only occur while idle.
// Depends on aafc_pkg, aafc_box_if and aafc_res_if.
module aabb_frustum_cull
  import aafc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  aafc_box_if.sink             in_box,
  aafc_res_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  logic [REG_W-1:0] mat_r [NUM_REGS];
  coord_t           ent [NUM_ROWS][NUM_ROWS];

  logic [NUM_STG-1:0] vld_r;
  logic               rdy [NUM_STG];

  coord_t lo_r [NUM_AXES];
  coord_t hi_r [NUM_AXES];

  // sel 1 = min coordinate, 0 = max coordinate
  logic signed [PROD_W-1:0] prod_nxt [NUM_ROWS][NUM_AXES][2];
  logic signed [PROD_W-1:0] prod_r   [NUM_ROWS][NUM_AXES][2];
  logic signed [PROD_W-1:0] kst_nxt  [NUM_ROWS];
  logic signed [PROD_W-1:0] kst_r    [NUM_ROWS];

  logic signed [PSUM_W-1:0] ax_nxt [NUM_ROWS][2];
  logic signed [PSUM_W-1:0] ax_r   [NUM_ROWS][2];
  logic signed [PSUM_W-1:0] yz_nxt [NUM_ROWS][4];
  logic signed [PSUM_W-1:0] yz_r   [NUM_ROWS][4];

  logic signed [CLIP_W-1:0] clip_nxt [NUM_CORN][NUM_ROWS];
  logic signed [CLIP_W-1:0] clip_r   [NUM_CORN][NUM_ROWS];

  logic [NUM_CORN-1:0] above_nxt [NUM_AXES];
  logic [NUM_CORN-1:0] above_r   [NUM_AXES];
  logic [NUM_CORN-1:0] below_nxt [NUM_AXES];
  logic [NUM_CORN-1:0] below_r   [NUM_AXES];

  logic vis_nxt;
  logic vis_r;

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_ROW0_COLS01] <= ONE_LOW;
      mat_r[REG_ROW0_COLS23] <= ZERO_REG;
      mat_r[REG_ROW1_COLS01] <= ONE_HIGH;
      mat_r[REG_ROW1_COLS23] <= ZERO_REG;
      mat_r[REG_ROW2_COLS01] <= ZERO_REG;
      mat_r[REG_ROW2_COLS23] <= ONE_LOW;
      mat_r[REG_ROW3_COLS01] <= ZERO_REG;
      mat_r[REG_ROW3_COLS23] <= ONE_HIGH;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg_index[REG_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        ent[r][c] = mat_r[REG_SEL_W'((r << 1) | (c >> 1))][(c & 1) * COORD_W +: COORD_W];
      end
    end
  end

  // per-stage ready chain
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_res.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_box.valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: products
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_nxt[r][a][1] = PROD_W'(ent[r][a]) * PROD_W'(lo_r[a]);
        prod_nxt[r][a][0] = PROD_W'(ent[r][a]) * PROD_W'(hi_r[a]);
      end
      kst_nxt[r] = PROD_W'(ent[r][NUM_AXES]) <<< FRAC_W;
    end
  end

  // stage 2: x term plus constant, y plus z terms
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int s = 0; s < 2; s++) begin
        ax_nxt[r][s] = PSUM_W'(prod_r[r][0][s]) + PSUM_W'(kst_r[r]);
      end
      for (int j = 0; j < 4; j++) begin
        yz_nxt[r][j] = PSUM_W'(prod_r[r][1][j & 1]) + PSUM_W'(prod_r[r][2][j >> 1]);
      end
    end
  end

  // stage 3: clip coordinates of each corner
  always_comb begin
    for (int i = 0; i < NUM_CORN; i++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        clip_nxt[i][r] = CLIP_W'(ax_r[r][i & 1]) + CLIP_W'(yz_r[r][i >> 1]);
      end
    end
  end

  // stage 4: plane tests
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int i = 0; i < NUM_CORN; i++) begin
        logic signed [CMP_W-1:0] diff;
        logic signed [CMP_W-1:0] sum;
        diff = CMP_W'(clip_r[i][a]) - CMP_W'(clip_r[i][NUM_AXES]);
        sum  = CMP_W'(clip_r[i][a]) + CMP_W'(clip_r[i][NUM_AXES]);
        above_nxt[a][i] = !diff[CMP_W-1] && (diff != '0);
        below_nxt[a][i] = sum[CMP_W-1];
      end
    end
  end

  // stage 5: reduction
  always_comb begin
    vis_nxt = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if ((&above_r[a]) || (&below_r[a])) begin
        vis_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lo_r[0] <= in_box.lo_x;
      lo_r[1] <= in_box.lo_y;
      lo_r[2] <= in_box.lo_z;
      hi_r[0] <= in_box.hi_x;
      hi_r[1] <= in_box.hi_y;
      hi_r[2] <= in_box.hi_z;
    end
    if (rdy[1]) begin
      prod_r <= prod_nxt;
      kst_r  <= kst_nxt;
    end
    if (rdy[2]) begin
      ax_r <= ax_nxt;
      yz_r <= yz_nxt;
    end
    if (rdy[3]) begin
      clip_r <= clip_nxt;
    end
    if (rdy[4]) begin
      above_r <= above_nxt;
      below_r <= below_nxt;
    end
    if (rdy[5]) begin
      vis_r <= vis_nxt;
    end
  end

  assign in_box.ready    = rdy[0];
  assign out_res.valid   = vld_r[NUM_STG-1];
  assign out_res.visible = vis_r;

endmodule

// ===== hw/rtl/aafc_checker.sv =====
// Port-level checker for the frustum cull block, bound to aabb_frustum_cull.
// Depends on aabb_frustum_cull_assert.svh and aabb_frustum_cull.
`include "aabb_frustum_cull_assert.svh"

module aafc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible
);

  // a held result stays put until taken
  `AAFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_visible))

  // an empty or draining output stage never blocks the input
  `AAFC_ASSERT_IMPL(a_in_ready, clk, rst_n, out_ready || !out_valid, in_ready)

  // no result is shown right out of reset
  `AAFC_ASSERT_IMPL(a_rst_empty, clk, rst_n, $rose(rst_n), !out_valid)

  // an item offered while the output stage is empty is taken
  `AAFC_ASSERT_IMPL(a_in_take, clk, rst_n, in_valid && !out_valid, in_ready)

endmodule

bind aabb_frustum_cull aafc_checker u_aafc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_box.valid),
  .in_ready    (in_box.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_visible (out_res.visible)
);

// ===== verif/aabb_frustum_cull_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of aabb_frustum_cull: directed and random boxes under random
// matrices and random stalls on both channels, checked against an exact clip-space predictor.
// Depends on aafc_pkg, aafc_box_if, aafc_res_if and the aabb_frustum_cull RTL.
module aabb_frustum_cull_tb;
  import aafc_pkg::*;

  localparam int GAP_MAX      = 11;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_BOXES = 1130;
  localparam int MAX_REPORTS  = 10;
  localparam coord_t Q_ONE    = 32'sh0001_0000;
  localparam coord_t Q_MAX    = 32'sh7FFF_FFFF;
  localparam coord_t Q_MIN    = 32'sh8000_0000;

  typedef enum int {MAT_SMALL, MAT_PERSPECTIVE, MAT_FULL, MAT_CORNER} mat_kind_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  aafc_box_if box_ch ();
  aafc_res_if res_ch ();

  aabb_frustum_cull dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_box    (box_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [REG_W-1:0] matrix_regs [NUM_REGS];
  logic             visible_q [$];
  logic             visible_exp;
  int               mismatches  = 0;
  int               idle_cycles = 0;
  int               src_gap_max = GAP_MAX;
  int               snk_gap_max = GAP_MAX;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic signed [127:0] mat_entry(int row, int col);
    logic [REG_W-1:0] r;
    coord_t           e;
    r = matrix_regs[row * 2 + col / 2];
    e = r[(col % 2) * 32 +: 32];
    return e;
  endfunction

  function automatic logic predict_visible(box_t b);
    logic signed [127:0] lo_v [3];
    logic signed [127:0] hi_v [3];
    logic signed [127:0] pt [3];
    logic signed [127:0] clip [8][4];
    logic                culled, above, below;
    lo_v[0] = b.lo_x;
    lo_v[1] = b.lo_y;
    lo_v[2] = b.lo_z;
    hi_v[0] = b.hi_x;
    hi_v[1] = b.hi_y;
    hi_v[2] = b.hi_z;
    for (int i = 0; i < 8; i++) begin
      for (int a = 0; a < 3; a++) pt[a] = ((i >> a) & 1) ? lo_v[a] : hi_v[a];
      for (int r = 0; r < 4; r++) begin
        clip[i][r] = mat_entry(r, 3) * Q_ONE;
        for (int a = 0; a < 3; a++) clip[i][r] = clip[i][r] + mat_entry(r, a) * pt[a];
      end
    end
    culled = 1'b0;
    for (int a = 0; a < 3; a++) begin
      above = 1'b1;
      below = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (!(clip[i][a] - clip[i][3] > 0)) above = 1'b0;
        if (!(clip[i][a] + clip[i][3] < 0)) below = 1'b0;
      end
      if (above || below) culled = 1'b1;
    end
    return !culled;
  endfunction

  function automatic box_t make_box(coord_t lx, coord_t ly, coord_t lz,
                                    coord_t hx, coord_t hy, coord_t hz);
    return '{lx, ly, lz, hx, hy, hz};
  endfunction

  function automatic box_t random_box(bit full_range);
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    int     ctr, ext;
    for (int a = 0; a < 3; a++) begin
      if (full_range) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        ctr   = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
        ext   = int'($urandom_range(0, 3 * 32768));
        lo[a] = ctr - ext;
        hi[a] = ctr + ext;
        if ($urandom_range(0, 9) == 0) begin
          t     = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
    end
    return '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  function automatic coord_t small_q();
    return int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
  endfunction

  function automatic coord_t pick_entry(mat_kind_t kind, int r, int c);
    coord_t corner_vals [5];
    corner_vals = '{Q_MIN, Q_MAX, 32'sd0, Q_ONE, -Q_ONE};
    case (kind)
      MAT_SMALL: return small_q();
      MAT_PERSPECTIVE: begin
        if (r == c && r < 2) return int'($urandom_range(32768, 2 * 65536));
        if (r == 2 && c >= 2) return small_q();
        if (r < 2 && c == 3) return small_q() >>> 2;
        if (r == 3 && c == 2) return -Q_ONE;
        return 32'sd0;
      end
      MAT_FULL: return $urandom;
      default: return corner_vals[$urandom_range(0, 4)];
    endcase
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(int idx, logic [REG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx[CFG_IDX_W-1:0];
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < NUM_REGS) matrix_regs[idx] = value;
  endtask

  task automatic write_matrix(coord_t m [4][4]);
    for (int r = 0; r < 4; r++)
      for (int h = 0; h < 2; h++) write_reg(r * 2 + h, {m[r][2 * h + 1], m[r][2 * h]});
  endtask

  task automatic wait_idle();
    box_ch.valid = 1'b0;
    while (visible_q.size() != 0) @(negedge clk);
    repeat (NUM_STG + 2) @(negedge clk);
  endtask

  task automatic send_box(box_t b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      box_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_ch.valid = 1'b1;
    box_ch.lo_x  = b.lo_x;
    box_ch.lo_y  = b.lo_y;
    box_ch.lo_z  = b.lo_z;
    box_ch.hi_x  = b.hi_x;
    box_ch.hi_y  = b.hi_y;
    box_ch.hi_z  = b.hi_z;
    do @(posedge clk); while (box_ch.ready !== 1'b1);
    visible_q.push_back(predict_visible(b));
    @(negedge clk);
  endtask

  // reset matrix is the identity
  task automatic test_identity_boxes();
    coord_t h, two, three;
    h     = Q_ONE >>> 1;
    two   = 2 * Q_ONE;
    three = 3 * Q_ONE;
    send_box(make_box(-h, -h, -h, h, h, h));
    send_box(make_box(two, -h, -h, three, h, h));
    send_box(make_box(-three, -h, -h, -two, h, h));
    send_box(make_box(-h, two, -h, h, three, h));
    send_box(make_box(-h, -three, -h, h, -two, h));
    send_box(make_box(-h, -h, two, h, h, three));
    send_box(make_box(-h, -h, -three, h, h, -two));
    send_box(make_box(h, -h, -h, two, h, h));
    send_box(make_box(Q_ONE, -h, -h, Q_ONE, h, h));
    send_box(make_box(three, -h, -h, two, h, h));
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
  endtask

  // full-scale entries, negative w included
  task automatic test_extreme_matrix();
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, {Q_MIN, Q_MAX});
    send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, {Q_MIN, Q_MIN});
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_box(make_box(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
  endtask

  task automatic test_bad_index();
    coord_t h;
    h = Q_ONE >>> 1;
    wait_idle();
    write_reg(REG_ROW0_COLS01, ONE_LOW);
    write_reg(REG_ROW0_COLS23, ZERO_REG);
    write_reg(REG_ROW1_COLS01, ONE_HIGH);
    write_reg(REG_ROW1_COLS23, ZERO_REG);
    write_reg(REG_ROW2_COLS01, ZERO_REG);
    write_reg(REG_ROW2_COLS23, ONE_LOW);
    write_reg(REG_ROW3_COLS01, ZERO_REG);
    write_reg(REG_ROW3_COLS23, ONE_HIGH);
    for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
      write_reg(i, (i % 2) ? '1 : {$urandom, $urandom});
    send_box(make_box(-h, -h, -h, h, h, h));
    send_box(make_box(2 * Q_ONE, -h, -h, 3 * Q_ONE, h, h));
  endtask

  task automatic test_random_frustums();
    coord_t    m [4][4];
    mat_kind_t kind;
    int        sent, count, phase;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BOXES) begin
      wait_idle();
      case (phase % 4)
        0: begin
          src_gap_max = GAP_MAX;
          snk_gap_max = GAP_MAX;
        end
        1: begin
          src_gap_max = 0;
          snk_gap_max = 0;
        end
        2: begin
          src_gap_max = GAP_MAX;
          snk_gap_max = 0;
        end
        default: begin
          src_gap_max = 0;
          snk_gap_max = GAP_MAX;
        end
      endcase
      kind = mat_kind_t'($urandom_range(0, 3));
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) m[r][c] = pick_entry(kind, r, c);
      write_matrix(m);
      count = $urandom_range(40, 120);
      for (int k = 0; k < count && sent < RANDOM_BOXES; k++) begin
        send_box(random_box($urandom_range(0, 99) >= 85));
        sent++;
      end
      phase++;
    end
  endtask

  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, snk_gap_max);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (visible_q.size() == 0) begin
        report($sformatf("unexpected result visible=%b", res_ch.visible));
      end else begin
        visible_exp = visible_q.pop_front();
        if (res_ch.visible !== visible_exp)
          report($sformatf("visible expected %b got %b", visible_exp, res_ch.visible));
      end
    end
  end

  always @(posedge clk) begin
    if ((box_ch.valid === 1'b1 && box_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || cfg_we === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    box_ch.valid = 1'b0;
    box_ch.lo_x  = '0;
    box_ch.lo_y  = '0;
    box_ch.lo_z  = '0;
    box_ch.hi_x  = '0;
    box_ch.hi_y  = '0;
    box_ch.hi_z  = '0;
    matrix_regs[REG_ROW0_COLS01] = ONE_LOW;
    matrix_regs[REG_ROW0_COLS23] = ZERO_REG;
    matrix_regs[REG_ROW1_COLS01] = ONE_HIGH;
    matrix_regs[REG_ROW1_COLS23] = ZERO_REG;
    matrix_regs[REG_ROW2_COLS01] = ZERO_REG;
    matrix_regs[REG_ROW2_COLS23] = ONE_LOW;
    matrix_regs[REG_ROW3_COLS01] = ZERO_REG;
    matrix_regs[REG_ROW3_COLS23] = ONE_HIGH;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_identity_boxes();
    test_extreme_matrix();
    test_bad_index();
    test_random_frustums();
    wait_idle();
    repeat (2 * NUM_STG) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== aabb_frustum_cull.f =====
+incdir+hw/rtl
hw/rtl/aafc_pkg.sv
hw/rtl/aafc_box_if.sv
hw/rtl/aafc_res_if.sv
hw/rtl/aabb_frustum_cull.sv
hw/rtl/aafc_checker.sv
verif/aabb_frustum_cull_tb.sv
